// File: rtl/fpck_pkg.sv
// ----------------------------------------------------------------------------
// fpck_pkg
// Shared types, key and operator codes and fixed-point helpers of the
// keypad calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpck_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 6;
    localparam int SYM_W  = 4;
    localparam int COUNT_W = 4;

    localparam logic [4:0] KEY_POINT   = 5'd10;
    localparam logic [4:0] KEY_PLUS    = 5'd11;
    localparam logic [4:0] KEY_MINUS   = 5'd12;
    localparam logic [4:0] KEY_TIMES   = 5'd13;
    localparam logic [4:0] KEY_DIVIDE  = 5'd14;
    localparam logic [4:0] KEY_EQUALS  = 5'd15;
    localparam logic [4:0] KEY_PERCENT = 5'd16;
    localparam logic [4:0] KEY_BACK    = 5'd17;
    localparam logic [4:0] KEY_CLEAR   = 5'd18;
    localparam logic [4:0] KEY_SIGN    = 5'd19;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_PLUS   = 3'd1;
    localparam logic [2:0] OP_MINUS  = 3'd2;
    localparam logic [2:0] OP_TIMES  = 3'd3;
    localparam logic [2:0] OP_DIVIDE = 3'd4;

    localparam logic [DATA_W-1:0] ONE_FIX     = 32'd1000;
    localparam logic [DATA_W-1:0] PCT_DIV     = 32'd100;
    localparam logic [DATA_W-1:0] QUOT_LIMIT  = 32'd2000000;
    localparam logic [DATA_W-1:0] FRAC_LIMIT  = 32'd2147483;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIVA,
        S_DIVB,
        S_PSTART,
        S_PARSE,
        S_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        P_IDLE,
        P_BODY,
        P_SCALE
    } parse_state_t;

    typedef enum logic [1:0] {
        MODE_DIV,
        MODE_MUL,
        MODE_PCT
    } arith_mode_t;

    function automatic logic [DATA_W-1:0] times10(input logic [DATA_W-1:0] x);
        times10 = (x << 3) + (x << 1);
    endfunction

    function automatic logic [DATA_W-1:0] times1000(input logic [DATA_W-1:0] x);
        times1000 = (x << 10) - (x << 4) - (x << 3);
    endfunction

    function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
        abs32 = x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

`default_nettype wire

// File: rtl/fixed_point_calculator_keypad.sv
// ----------------------------------------------------------------------------
// fixed_point_calculator_keypad
// Four-function keypad calculator in thousandths, one key request per item.
// ----------------------------------------------------------------------------
// Flow: every key passes through the symbol-serial entry parser before its
//   result is loaded. Multiply adds two passes (shift-add multiplier, then
//   restoring divider); divide adds up to two divider passes, percent one.
// Throughput: one key at a time; the next key is taken once the result sits
//   in the output register. Reset clears the calculator state and both
//   handshakes asynchronously; the entry store and arithmetic scratch
//   registers are not reset.
`default_nettype none

module fixed_point_calculator_keypad #(
    parameter int MAX_ENTRY = 10
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // key[4:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata    // accumulator, entry_value, showing_entry,
                                   // pending_operation, error_flag, entry_count
);
    import fpck_pkg::*;

    localparam int BW = $clog2(MAX_ENTRY + 1);
    localparam int IW = $clog2(MAX_ENTRY);
    localparam int LW = BW + 1;

    ctl_state_t        state_reg, state_next;
    arith_mode_t       mode_reg, mode_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] entval_reg, entval_next;
    logic [DATA_W-1:0] ub_reg, ub_next;
    logic [DATA_W-1:0] qk_reg, qk_next;
    logic              sign_reg, sign_next;
    logic [2:0]        op_reg, op_next;
    logic              fresh_reg, fresh_next;
    logic              fault_reg, fault_next;
    logic [BW-1:0]     blen_reg, blen_next;
    logic              neg_reg, neg_next;
    logic              haspt_reg, haspt_next;
    logic [IW-1:0]     ptidx_reg, ptidx_next;
    logic [SYM_W-1:0]  body_reg [MAX_ENTRY];
    logic              out_valid_reg, out_valid_next;
    logic [79:0]       out_data_reg;

    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    logic [SYM_W-1:0]  wr_dat;

    logic [4:0]        key;
    logic              s_acc;
    logic              out_load;
    logic [DATA_W-1:0] b_op;
    logic              is_op;
    logic              go_mul, go_diva, go_pct;
    logic              mul_ok, q_bad, ubig;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_a, div_b, div_q, div_r;
    logic              mul_start, mul_done;
    logic [2*DATA_W-1:0] mul_p;
    logic              parse_start, parse_done;
    logic [IW-1:0]     rd_idx;
    logic [DATA_W-1:0] parse_val;

    logic [BW-1:0]     base_blen;
    logic              base_neg, base_pt, base_fresh;
    logic [LW-1:0]     base_len;
    logic [BW-1:0]     blen_m1;
    logic [DATA_W-1:0] mag;

    assign key    = s_tdata[4:0];
    assign s_acc  = s_tvalid && s_tready;
    assign b_op   = fresh_reg ? acc_reg : entval_reg;
    assign is_op  = (key >= KEY_PLUS) && (key <= KEY_EQUALS) && !fault_reg;
    assign go_mul  = s_acc && is_op && (op_reg == OP_TIMES);
    assign go_diva = s_acc && is_op && (op_reg == OP_DIVIDE) && (b_op != '0);
    assign go_pct  = s_acc && (key == KEY_PERCENT) && !fault_reg;
    assign mul_ok  = (mul_p[2*DATA_W-1:DATA_W-1] == '0);
    assign q_bad   = (div_q > QUOT_LIMIT);
    assign ubig    = (ub_reg > FRAC_LIMIT);
    assign blen_m1 = blen_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go_mul)
                    state_next = S_MUL;
                else if (go_diva)
                    state_next = S_DIVA;
                else if (go_pct)
                    state_next = S_DIVB;
                else if (s_acc)
                    state_next = S_PSTART;
            end
            S_MUL:
            begin
                if (mul_done)
                    state_next = mul_ok ? S_DIVB : S_PSTART;
            end
            S_DIVA:
            begin
                if (div_done)
                    state_next = (!q_bad && !ubig) ? S_DIVB : S_PSTART;
            end
            S_DIVB:
            begin
                if (div_done)
                    state_next = S_PSTART;
            end
            S_PSTART: state_next = S_PARSE;
            S_PARSE:
            begin
                if (parse_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // unit control
    always_comb
    begin
        s_tready    = (state_reg == S_IDLE);
        out_load    = (state_reg == S_OUT) && (!out_valid_reg || m_tready);
        parse_start = (state_reg == S_PSTART);
        mul_start   = go_mul;
        div_start   = 1'b0;
        div_a       = abs32(acc_reg);
        div_b       = abs32(b_op);
        case (state_reg)
            S_IDLE:
            begin
                if (go_diva)
                    div_start = 1'b1;
                else if (go_pct)
                begin
                    div_start = 1'b1;
                    div_a     = abs32(b_op);
                    div_b     = PCT_DIV;
                end
            end
            S_MUL:
            begin
                div_start = mul_done && mul_ok;
                div_a     = mul_p[DATA_W-1:0];
                div_b     = ONE_FIX;
            end
            S_DIVA:
            begin
                div_start = div_done && !q_bad && !ubig;
                div_a     = times1000(div_r);
                div_b     = ub_reg;
            end
            default: ;
        endcase
    end

    // calculator state
    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        entval_next = entval_reg;
        ub_next     = ub_reg;
        qk_next     = qk_reg;
        sign_next   = sign_reg;
        op_next     = op_reg;
        fresh_next  = fresh_reg;
        fault_next  = fault_reg;
        blen_next   = blen_reg;
        neg_next    = neg_reg;
        haspt_next  = haspt_reg;
        ptidx_next  = ptidx_reg;
        wr_en       = 1'b0;
        wr_idx      = '0;
        wr_dat      = '0;
        base_blen   = blen_reg;
        base_neg    = neg_reg;
        base_pt     = haspt_reg;
        base_fresh  = fresh_reg;
        base_len    = '0;
        mag         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    if (key <= KEY_POINT)
                    begin
                        if (fault_reg)
                        begin
                            acc_next   = '0;
                            op_next    = OP_NONE;
                            fault_next = 1'b0;
                            base_fresh = 1'b1;
                        end
                        if (base_fresh)
                        begin
                            base_blen = '0;
                            base_neg  = 1'b0;
                            base_pt   = 1'b0;
                        end
                        fresh_next = 1'b0;
                        blen_next  = base_blen;
                        neg_next   = base_neg;
                        haspt_next = base_pt;
                        base_len   = LW'(base_blen) + LW'(base_neg);
                        if (base_len < LW'(MAX_ENTRY))
                        begin
                            if (key == KEY_POINT)
                            begin
                                if (!base_pt)
                                begin
                                    haspt_next = 1'b1;
                                    if (base_blen == '0)
                                    begin
                                        wr_en      = 1'b1;
                                        ptidx_next = IW'(1);
                                        blen_next  = BW'(2);
                                    end
                                    else
                                    begin
                                        ptidx_next = base_blen[IW-1:0];
                                        blen_next  = base_blen + 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_idx    = base_blen[IW-1:0];
                                wr_dat    = key[SYM_W-1:0];
                                blen_next = base_blen + 1'b1;
                            end
                        end
                    end
                    else if (key <= KEY_EQUALS)
                    begin
                        if (!fault_reg)
                        begin
                            op_next    = (key == KEY_EQUALS) ? OP_NONE
                                                             : 3'(key - KEY_POINT);
                            fresh_next = 1'b1;
                            blen_next  = '0;
                            neg_next   = 1'b0;
                            haspt_next = 1'b0;
                            sign_next  = acc_reg[DATA_W-1] ^ b_op[DATA_W-1];
                            ub_next    = abs32(b_op);
                            case (op_reg)
                                OP_PLUS:  acc_next = acc_reg + b_op;
                                OP_MINUS: acc_next = acc_reg - b_op;
                                OP_TIMES: mode_next = MODE_MUL;
                                OP_DIVIDE:
                                begin
                                    mode_next = MODE_DIV;
                                    if (b_op == '0)
                                    begin
                                        fault_next = 1'b1;
                                        acc_next   = '0;
                                    end
                                end
                                default:  acc_next = b_op;
                            endcase
                        end
                    end
                    else if (key == KEY_PERCENT)
                    begin
                        if (!fault_reg)
                        begin
                            mode_next  = MODE_PCT;
                            sign_next  = b_op[DATA_W-1];
                            op_next    = OP_NONE;
                            fresh_next = 1'b1;
                            blen_next  = '0;
                            neg_next   = 1'b0;
                            haspt_next = 1'b0;
                        end
                    end
                    else if ((key == KEY_CLEAR) || ((key == KEY_BACK) && fault_reg))
                    begin
                        acc_next   = '0;
                        op_next    = OP_NONE;
                        fault_next = 1'b0;
                        fresh_next = 1'b1;
                        blen_next  = '0;
                        neg_next   = 1'b0;
                        haspt_next = 1'b0;
                    end
                    else if (key == KEY_BACK)
                    begin
                        if (!fresh_reg)
                        begin
                            blen_next = blen_m1;
                            if (haspt_reg && (ptidx_reg == blen_m1[IW-1:0]))
                                haspt_next = 1'b0;
                            if (blen_m1 == '0)
                            begin
                                fresh_next = 1'b1;
                                acc_next   = '0;
                                neg_next   = 1'b0;
                            end
                        end
                    end
                    else if (key == KEY_SIGN)
                    begin
                        if (!fault_reg)
                        begin
                            if (fresh_reg)
                                acc_next = ~acc_reg + 1'b1;
                            else
                                neg_next = !neg_reg;
                        end
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done && !mul_ok)
                begin
                    fault_next = 1'b1;
                    acc_next   = '0;
                end
            end
            S_DIVA:
            begin
                if (div_done)
                begin
                    qk_next = times1000(div_q);
                    if (q_bad)
                    begin
                        fault_next = 1'b1;
                        acc_next   = '0;
                    end
                    else if (ubig)
                    begin
                        mag      = times1000(div_q);
                        acc_next = sign_reg ? (~mag + 1'b1) : mag;
                    end
                end
            end
            S_DIVB:
            begin
                if (div_done)
                begin
                    mag      = (mode_reg == MODE_DIV) ? (qk_reg + div_q) : div_q;
                    acc_next = sign_reg ? (~mag + 1'b1) : mag;
                end
            end
            S_PARSE:
            begin
                if (parse_done)
                    entval_next = parse_val;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            entval_reg    <= '0;
            op_reg        <= OP_NONE;
            fresh_reg     <= 1'b1;
            fault_reg     <= 1'b0;
            blen_reg      <= '0;
            neg_reg       <= 1'b0;
            haspt_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            entval_reg    <= entval_next;
            op_reg        <= op_next;
            fresh_reg     <= fresh_next;
            fault_reg     <= fault_next;
            blen_reg      <= blen_next;
            neg_reg       <= neg_next;
            haspt_reg     <= haspt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        ub_reg    <= ub_next;
        qk_reg    <= qk_next;
        sign_reg  <= sign_next;
        ptidx_reg <= ptidx_next;
        if (wr_en)
            body_reg[wr_idx] <= wr_dat;
        if (out_load)
            out_data_reg <= {7'd0,
                             COUNT_W'(blen_reg) + COUNT_W'(neg_reg),
                             fault_reg,
                             op_reg,
                             !fresh_reg,
                             entval_reg,
                             acc_reg};
    end

    fpck_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    fpck_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (abs32(acc_reg)),
        .b       (abs32(b_op)),
        .done    (mul_done),
        .product (mul_p)
    );

    fpck_parse #(
        .MAX_ENTRY (MAX_ENTRY)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (parse_start),
        .blen    (blen_reg),
        .neg     (neg_reg),
        .has_pt  (haspt_reg),
        .pt_idx  (ptidx_reg),
        .rd_data (body_reg[rd_idx]),
        .rd_idx  (rd_idx),
        .done    (parse_done),
        .value   (parse_val)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/fpck_div.sv
// ----------------------------------------------------------------------------
// fpck_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpck_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire  [fpck_pkg::DATA_W-1:0]  dividend,
    input  wire  [fpck_pkg::DATA_W-1:0]  divisor,
    output logic                         done,
    output logic [fpck_pkg::DATA_W-1:0]  quot,
    output logic [fpck_pkg::DATA_W-1:0]  rem
);
    import fpck_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        d_next    = d_reg;
        trial     = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, d_reg};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/fpck_mul.sv
// ----------------------------------------------------------------------------
// fpck_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpck_mul (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire  [fpck_pkg::DATA_W-1:0]    a,
    input  wire  [fpck_pkg::DATA_W-1:0]    b,
    output logic                           done,
    output logic [2*fpck_pkg::DATA_W-1:0]  product
);
    import fpck_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W:0]   sum;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            hi_next  = '0;
            lo_next  = b;
            a_next   = a;
        end
        else if (run_reg)
        begin
            hi_next  = sum[DATA_W:1];
            lo_next  = {sum[0], lo_reg[DATA_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// File: rtl/fpck_parse.sv
// ----------------------------------------------------------------------------
// fpck_parse
// Entry parser: walks the entry one symbol per cycle into thousandths.
// ----------------------------------------------------------------------------
`default_nettype none

module fpck_parse #(
    parameter int MAX_ENTRY = 10
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    input  wire  [$clog2(MAX_ENTRY+1)-1:0]       blen,
    input  wire                                  neg,
    input  wire                                  has_pt,
    input  wire  [$clog2(MAX_ENTRY)-1:0]         pt_idx,
    input  wire  [fpck_pkg::SYM_W-1:0]           rd_data,
    output logic [$clog2(MAX_ENTRY)-1:0]         rd_idx,
    output logic                                 done,
    output logic [fpck_pkg::DATA_W-1:0]          value
);
    import fpck_pkg::*;

    localparam int BW = $clog2(MAX_ENTRY + 1);
    localparam int IW = $clog2(MAX_ENTRY);

    parse_state_t      state_reg, state_next;
    logic [BW-1:0]     idx_reg, idx_next;
    logic              frac_reg, frac_next;
    logic [1:0]        digs_reg, digs_next;
    logic [1:0]        scl_reg, scl_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] v_reg, v_next;
    logic              at_end;
    logic              at_point;

    assign at_end   = (idx_reg == blen);
    assign at_point = has_pt && (idx_reg == BW'(pt_idx));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            P_IDLE:
            begin
                if (start)
                    state_next = P_BODY;
            end
            P_BODY:
            begin
                if (at_end)
                    state_next = P_SCALE;
            end
            P_SCALE:
            begin
                if (scl_reg == 2'd0)
                    state_next = P_IDLE;
            end
            default: state_next = P_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        frac_next = frac_reg;
        digs_next = digs_reg;
        scl_next  = scl_reg;
        neg_next  = neg_reg;
        v_next    = v_reg;
        done_next = 1'b0;
        case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    idx_next  = '0;
                    frac_next = 1'b0;
                    digs_next = 2'd0;
                    neg_next  = neg;
                    v_next    = '0;
                end
            end
            P_BODY:
            begin
                if (at_end)
                    scl_next = frac_reg ? (2'd3 - digs_reg) : 2'd3;
                else
                begin
                    if (at_point)
                        frac_next = 1'b1;
                    else if (!frac_reg)
                        v_next = times10(v_reg) + DATA_W'(rd_data);
                    else if (digs_reg != 2'd3)
                    begin
                        v_next    = times10(v_reg) + DATA_W'(rd_data);
                        digs_next = digs_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            P_SCALE:
            begin
                if (scl_reg == 2'd0)
                begin
                    v_next    = neg_reg ? (~v_reg + 1'b1) : v_reg;
                    done_next = 1'b1;
                end
                else
                begin
                    v_next   = times10(v_reg);
                    scl_next = scl_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        frac_reg <= frac_next;
        digs_reg <= digs_next;
        scl_reg  <= scl_next;
        neg_reg  <= neg_next;
        v_reg    <= v_next;
    end

    assign rd_idx = idx_reg[IW-1:0];
    assign done   = done_reg;
    assign value  = v_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Keypad calculator check: key requests are driven through the slave stream,
// a behavioural calculator in the scoreboard predicts each display result,
// and the master stream results are compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

import fpck_pkg::*;

typedef struct packed {
    logic [3:0]  entry_count;
    logic        error_flag;
    logic [2:0]  pending_operation;
    logic        showing_entry;
    logic [31:0] entry_value;
    logic [31:0] accumulator;
} calc_result_t;

class calc_scoreboard;
    localparam logic [3:0]  SYM_POINT = 4'd10;
    localparam logic [3:0]  SYM_MINUS = 4'd11;
    localparam int unsigned ENTRY_MAX = 10;

    logic [3:0]   symbols[12];
    int unsigned  len;
    logic [31:0]  acc;
    logic [2:0]   op;
    bit           fresh;
    bit           fault;
    calc_result_t pending_q[$];
    int           mismatches;

    function void reset_state();
        len = 0;
        acc = 0;
        op = OP_NONE;
        fresh = 1;
        fault = 0;
    endfunction

    function logic [31:0] entry_fix();
        logic [31:0] v;
        int unsigned i, st, digs;
        bit frac, neg;
        v = 0;
        st = 0;
        digs = 0;
        frac = 0;
        neg = 0;
        if (len > 0 && symbols[0] == SYM_MINUS)
        begin
            neg = 1;
            st = 1;
        end
        for (i = st; i < len && i < 12; i++)
        begin
            if (symbols[i] == SYM_POINT)
                frac = 1;
            else if (symbols[i] <= 4'd9)
            begin
                if (!frac)
                    v = v * 10 + symbols[i];
                else if (digs < 3)
                begin
                    v = v * 10 + symbols[i];
                    digs++;
                end
            end
        end
        if (frac)
        begin
            while (digs < 3)
            begin
                v = v * 10;
                digs++;
            end
        end
        else
            v = v * 1000;
        return neg ? -v : v;
    endfunction

    function logic [31:0] combine(logic [31:0] a, logic [31:0] b, logic [2:0] o);
        longint sa, sb, q, r, ma, mb;
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        case (o)
            OP_PLUS:  return a + b;
            OP_MINUS: return a - b;
            OP_TIMES:
            begin
                ma = sa < 0 ? -sa : sa;
                mb = sb < 0 ? -sb : sb;
                if (ma * mb > 64'd2147483647)
                begin
                    fault = 1;
                    return 0;
                end
                return 32'((sa * sb) / 1000);
            end
            OP_DIVIDE:
            begin
                if (sb == 0)
                begin
                    fault = 1;
                    return 0;
                end
                q = sa / sb;
                r = sa - q * sb;
                if (q > 2000000 || q < -2000000)
                begin
                    fault = 1;
                    return 0;
                end
                if (sb > 2147483 || sb < -2147483)
                    return 32'(q * 1000);
                return 32'(q * 1000 + (r * 1000) / sb);
            end
            default: return b;
        endcase
    endfunction

    function void complete(logic [2:0] next_op);
        logic [31:0] b;
        b = fresh ? acc : entry_fix();
        acc = (op != OP_NONE) ? combine(acc, b, op) : b;
        op = next_op;
        fresh = 1;
        len = 0;
    endfunction

    function void note_key(logic [4:0] k);
        int unsigned i;
        bit dup;
        logic [31:0] b;
        calc_result_t r;
        if (k <= KEY_POINT)
        begin
            if (fault)
                reset_state();
            if (fresh)
            begin
                len = 0;
                fresh = 0;
            end
            if (len < ENTRY_MAX)
            begin
                dup = 0;
                if (k == KEY_POINT)
                begin
                    for (i = 0; i < len; i++)
                        if (symbols[i] == SYM_POINT)
                            dup = 1;
                    if (!dup && len == 0)
                    begin
                        symbols[0] = 4'd0;
                        len = 1;
                    end
                end
                if (!dup)
                begin
                    symbols[len] = k[3:0];
                    len++;
                end
            end
        end
        else if (k < KEY_EQUALS)
        begin
            if (!fault)
                complete(3'(k - KEY_POINT));
        end
        else if (k == KEY_EQUALS)
        begin
            if (!fault)
                complete(OP_NONE);
        end
        else if (k == KEY_PERCENT)
        begin
            if (!fault)
            begin
                b = fresh ? acc : entry_fix();
                acc = 32'(longint'(signed'(b)) / 100);
                op = OP_NONE;
                fresh = 1;
                len = 0;
            end
        end
        else if (k == KEY_BACK)
        begin
            if (fault)
                reset_state();
            else if (!fresh)
            begin
                if (len > 0)
                    len--;
                if (len == 0 || (len == 1 && symbols[0] == SYM_MINUS))
                begin
                    len = 0;
                    fresh = 1;
                    acc = 0;
                end
            end
        end
        else if (k == KEY_CLEAR)
            reset_state();
        else if (k == KEY_SIGN && !fault)
        begin
            if (fresh)
                acc = -acc;
            else if (len > 0 && symbols[0] == SYM_MINUS)
            begin
                for (i = 0; i + 1 < len; i++)
                    symbols[i] = symbols[i + 1];
                len--;
            end
            else if (len < 11)
            begin
                for (i = len; i > 0; i--)
                    symbols[i] = symbols[i - 1];
                symbols[0] = SYM_MINUS;
                len++;
            end
        end
        r.accumulator = acc;
        r.entry_value = entry_fix();
        r.showing_entry = !fresh;
        r.pending_operation = op;
        r.error_flag = fault;
        r.entry_count = len[3:0];
        pending_q.push_back(r);
    endfunction

    function void check_result(calc_result_t got);
        calc_result_t want;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", got);
            return;
        end
        want = pending_q.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result mismatch: acc exp %0d got %0d, entry exp %0d got %0d",
                         signed'(want.accumulator), signed'(got.accumulator),
                         signed'(want.entry_value), signed'(got.entry_value));
                $display("  show exp %b got %b, op exp %0d got %0d",
                         want.showing_entry, got.showing_entry,
                         want.pending_operation, got.pending_operation);
                $display("  err exp %b got %b, count exp %0d got %0d",
                         want.error_flag, got.error_flag,
                         want.entry_count, got.entry_count);
            end
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    calc_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  quiet_cycles;
    int  keys_sent;

    fixed_point_calculator_keypad uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_key(s_tdata[4:0]);
            if (m_tvalid && m_tready)
                sb.check_result(calc_result_t'(m_tdata[72:0]));
        end
    end

    // receiver side
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on acceptance activity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles > 20000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // valid stays high between back-to-back requests; idle_bus drops it
    task automatic press(input logic [4:0] k);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {3'b000, k};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        keys_sent++;
        @(negedge clk);
    endtask

    task automatic idle_bus();
        s_tvalid <= 1'b0;
    endtask

    task automatic press_number();
        int n, i;
        n = int'($urandom_range(7, 1));
        if ($urandom_range(9) == 0)
            n = 12;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(5) == 0)
                press(KEY_POINT);
            else
                press(5'($urandom_range(9)));
        end
        if ($urandom_range(4) == 0)
            press(KEY_SIGN);
        if ($urandom_range(9) == 0)
            press(KEY_BACK);
    endtask

    task automatic random_phase(input int items);
        int target;
        target = keys_sent + items;
        while (keys_sent < target)
        begin
            case ($urandom_range(9))
                0: press(5'($urandom_range(31)));
                1: press(5'($urandom_range(KEY_SIGN, KEY_EQUALS)));
                default:
                begin
                    press_number();
                    press(5'($urandom_range(KEY_EQUALS, KEY_PLUS)));
                end
            endcase
        end
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        keys_sent = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;

        // directed: every key, full entry, divide by zero, error keys
        for (int i = 0; i < 20; i++)
            press(5'(i));
        press(5'd31);
        press(5'd9); press(5'd9); press(5'd9); press(KEY_MINUS);
        press(5'd9); press(5'd9); press(5'd9); press(KEY_EQUALS);
        press(KEY_SIGN); press(KEY_TIMES); press(5'd0); press(KEY_EQUALS);
        press(KEY_PLUS); press(5'd5); press(KEY_BACK); press(KEY_CLEAR);
        // multiply overflow, then a divide with a fraction
        repeat (5) press(5'd9);
        press(KEY_TIMES);
        repeat (5) press(5'd9);
        press(KEY_EQUALS); press(KEY_CLEAR);
        press(5'd7); press(KEY_DIVIDE); press(5'd3); press(KEY_EQUALS);

        // long receiver hold-off while keys keep coming
        fork
            begin
                hold_off = 1;
                repeat (3000) @(negedge clk);
                hold_off = 0;
            end
            repeat (10) press(5'($urandom_range(19)));
        join
        idle_bus();
        drain();

        random_phase(175);
        idle_bus();
        drain();
        send_idle_pct = 48; random_phase(175);
        send_idle_pct = 0; recv_stall_pct = 48; random_phase(175);
        send_idle_pct = 10; recv_stall_pct = 10; random_phase(175);
        idle_bus();
        send_idle_pct = 0; recv_stall_pct = 0;
        drain();

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
rtl/fpck_pkg.sv
rtl/fpck_div.sv
rtl/fpck_mul.sv
rtl/fpck_parse.sv
rtl/fixed_point_calculator_keypad.sv
tb/tb_top.sv
